/* design/dnsqe_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and byte tables for the DNS query encoder.
// Used by dnsqe_front, dnsqe_cmd_queue, dnsqe_back and the top level.
package dnsqe_pkg;

    // Input operation codes.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_CHAR  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    // Wide enough for the largest supported label bound.
    localparam int LEN_W = 6;
    localparam int HDR_BYTES = 12;
    localparam int TRL_BYTES = 5;

    // Command kinds passed from the front to the back.
    localparam logic [1:0] CMD_START     = 2'd0;
    localparam logic [1:0] CMD_LABEL     = 2'd1;
    localparam logic [1:0] CMD_LABEL_END = 2'd2;
    localparam logic [1:0] CMD_END       = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [15:0]      id;
        logic [LEN_W-1:0] len;
        logic             cut;
    } cmd_t;

    typedef struct packed {
        logic             en;
        logic [LEN_W-1:0] addr;
        logic [7:0]       data;
    } mem_wr_t;

    function automatic logic [7:0] hdr_byte(input logic [LEN_W-1:0] idx,
                                            input logic [15:0] id);
        logic [7:0] b;
        case (idx)
            LEN_W'(0): b = id[7:0];
            LEN_W'(1): b = id[15:8];
            LEN_W'(2): b = 8'h01;
            LEN_W'(5): b = 8'h01;
            default:   b = 8'h00;
        endcase
        return b;
    endfunction

    // Trailer: root label, type A, class IN.
    function automatic logic [7:0] trl_byte(input logic [LEN_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            LEN_W'(2): b = 8'h01;
            LEN_W'(4): b = 8'h01;
            default:   b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* design/dnsqe_front.sv */
`timescale 1ns / 1ps
// Front end: accepts input transactions, buffers label characters into the
// label store and issues commands to the queue. Depends on dnsqe_pkg.
module dnsqe_front
    import dnsqe_pkg::*;
#(
    parameter int MAX_LABEL = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       op,
    input  logic [7:0]       name_char,
    input  logic [15:0]      request_id,
    input  logic             q_full,
    output logic             q_push,
    output cmd_t             q_cmd,
    output mem_wr_t          mem_wr,
    input  logic             label_done
);

    logic [LEN_W-1:0] len_reg, len_next;
    logic             cut_reg, cut_next;
    // A label flush is in flight; the store must not be rewritten until read.
    logic             pend_reg, pend_next;
    logic             accept;

    assign in_ready = !q_full && !pend_reg;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        len_next     = len_reg;
        cut_next     = cut_reg;
        pend_next    = pend_reg && !label_done;
        q_push       = 1'b0;
        q_cmd.kind   = CMD_START;
        q_cmd.id     = request_id;
        q_cmd.len    = len_reg;
        q_cmd.cut    = cut_reg;
        mem_wr.en    = 1'b0;
        mem_wr.addr  = len_reg;
        mem_wr.data  = name_char;
        if (accept)
        begin
            case (op)
                OP_START:
                begin
                    q_push   = 1'b1;
                    len_next = '0;
                    cut_next = 1'b0;
                end
                OP_CHAR:
                begin
                    if (name_char == DOT_CHAR)
                    begin
                        if (len_reg != '0)
                        begin
                            q_push     = 1'b1;
                            q_cmd.kind = CMD_LABEL;
                            pend_next  = 1'b1;
                        end
                        len_next = '0;
                        cut_next = 1'b0;
                    end
                    else if (len_reg < LEN_W'(MAX_LABEL))
                    begin
                        mem_wr.en = 1'b1;
                        len_next  = len_reg + LEN_W'(1);
                    end
                    else
                    begin
                        cut_next = 1'b1;
                    end
                end
                OP_END:
                begin
                    q_push = 1'b1;
                    if (len_reg != '0)
                    begin
                        q_cmd.kind = CMD_LABEL_END;
                        pend_next  = 1'b1;
                    end
                    else
                    begin
                        q_cmd.kind = CMD_END;
                    end
                    len_next = '0;
                    cut_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            cut_reg  <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            cut_reg  <= cut_next;
            pend_reg <= pend_next;
        end
    end

endmodule

/* design/dnsqe_cmd_queue.sv */
`timescale 1ns / 1ps
// Two-entry command queue between the front and back ends.
// Depends on dnsqe_pkg for the command type.
module dnsqe_cmd_queue
    import dnsqe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/dnsqe_back.sv */
`timescale 1ns / 1ps
// Back end: holds the label store and serializes each command into message
// bytes on a registered output port. Depends on dnsqe_pkg.
module dnsqe_back
    import dnsqe_pkg::*;
#(
    parameter int MAX_LABEL = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  mem_wr_t    mem_wr,
    input  logic       q_valid,
    input  cmd_t       q_head,
    output logic       q_pop,
    output logic       label_done,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       end_of_query,
    output logic       label_overflow
);

    localparam int IDX_W = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HDR  = 3'd1;
    localparam logic [2:0] ST_LEN  = 3'd2;
    localparam logic [2:0] ST_CHR  = 3'd3;
    localparam logic [2:0] ST_TRL  = 3'd4;

    logic [7:0]       store_mem [MAX_LABEL];
    logic [7:0]       rd_data_reg;
    logic             rd_en;
    logic [LEN_W-1:0] rd_addr;

    logic [2:0]       state_reg, state_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    cmd_t             cmd_reg, cmd_next;

    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic             eoq_reg, eoq_next;
    logic             ovf_reg, ovf_next;
    logic             load;

    // The output register can take a new byte when empty or being drained.
    assign load = !valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd_next   = cmd_reg;
        q_pop      = 1'b0;
        label_done = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        valid_next = valid_reg && !out_ready;
        byte_next  = byte_reg;
        last_next  = last_reg;
        eoq_next   = eoq_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_head;
                    cnt_next = '0;
                    case (q_head.kind)
                        CMD_START:     state_next = ST_HDR;
                        CMD_LABEL:     state_next = ST_LEN;
                        CMD_LABEL_END: state_next = ST_LEN;
                        default:       state_next = ST_TRL;
                    endcase
                end
            end
            ST_HDR:
            begin
                if (load)
                begin
                    valid_next = 1'b1;
                    byte_next  = hdr_byte(cnt_reg, cmd_reg.id);
                    last_next  = (cnt_reg == LEN_W'(HDR_BYTES - 1));
                    eoq_next   = 1'b0;
                    ovf_next   = 1'b0;
                    cnt_next   = cnt_reg + LEN_W'(1);
                    if (cnt_reg == LEN_W'(HDR_BYTES - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_LEN:
            begin
                if (load)
                begin
                    valid_next = 1'b1;
                    byte_next  = 8'(cmd_reg.len);
                    last_next  = 1'b0;
                    eoq_next   = 1'b0;
                    ovf_next   = cmd_reg.cut;
                    rd_en      = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_CHR;
                end
            end
            ST_CHR:
            begin
                if (load)
                begin
                    valid_next = 1'b1;
                    byte_next  = rd_data_reg;
                    eoq_next   = 1'b0;
                    ovf_next   = cmd_reg.cut;
                    if (cnt_reg == cmd_reg.len - LEN_W'(1))
                    begin
                        label_done = 1'b1;
                        cnt_next   = '0;
                        last_next  = (cmd_reg.kind == CMD_LABEL);
                        state_next = (cmd_reg.kind == CMD_LABEL) ? ST_IDLE : ST_TRL;
                    end
                    else
                    begin
                        // Fetch the next character while this one goes out.
                        last_next = 1'b0;
                        rd_en     = 1'b1;
                        rd_addr   = cnt_reg + LEN_W'(1);
                        cnt_next  = cnt_reg + LEN_W'(1);
                    end
                end
            end
            ST_TRL:
            begin
                if (load)
                begin
                    valid_next = 1'b1;
                    byte_next  = trl_byte(cnt_reg);
                    last_next  = (cnt_reg == LEN_W'(TRL_BYTES - 1));
                    eoq_next   = (cnt_reg == LEN_W'(TRL_BYTES - 1));
                    ovf_next   = 1'b0;
                    cnt_next   = cnt_reg + LEN_W'(1);
                    if (cnt_reg == LEN_W'(TRL_BYTES - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
        begin
            store_mem[mem_wr.addr[IDX_W-1:0]] <= mem_wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        eoq_reg  <= eoq_next;
        ovf_reg  <= ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid      = valid_reg;
    assign out_byte       = byte_reg;
    assign last_of_run    = last_reg;
    assign end_of_query   = eoq_reg;
    assign label_overflow = ovf_reg;

endmodule

/* design/dns_query_message_encoder_core.sv */
`timescale 1ns / 1ps
// DNS A-record query encoder: turns start, character and end transactions into
// the byte stream of a standard query. Every input transaction is taken in the
// cycle in which it is accepted; start, flushed-label and end transactions are
// queued as commands, and the back end emits one byte per cycle from its output
// register unless out_ready stalls it, after a dispatch state per command; a
// trailer that follows the last label of the same end transaction skips that
// dispatch. All input transactions stall from the moment a label flush is queued
// until its last character has been loaded into the output register, and also
// while the command queue is full. A start transaction clears any label still
// buffered; labels longer than MAX_LABEL (1 to 63) are cut and flagged on every
// byte of that label.
module dns_query_message_encoder_core
    import dnsqe_pkg::*;
#(
    parameter int MAX_LABEL = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  name_char,
    input  logic [15:0] request_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_of_run,
    output logic        end_of_query,
    output logic        label_overflow
);

    logic    q_full;
    logic    q_push;
    logic    q_pop;
    logic    q_valid;
    cmd_t    q_cmd;
    cmd_t    q_head;
    mem_wr_t mem_wr;
    logic    label_done;

    dnsqe_front #(
        .MAX_LABEL (MAX_LABEL)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .name_char  (name_char),
        .request_id (request_id),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_cmd),
        .mem_wr     (mem_wr),
        .label_done (label_done)
    );

    dnsqe_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    dnsqe_back #(
        .MAX_LABEL (MAX_LABEL)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .mem_wr         (mem_wr),
        .q_valid        (q_valid),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .label_done     (label_done),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .last_of_run    (last_of_run),
        .end_of_query   (end_of_query),
        .label_overflow (label_overflow)
    );

endmodule
